// ===== design/pwlock_pkg.sv =====
// ----------------------------------------------------------------------------
// Password lock package
// Shared types, codes and register defaults for the password lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlock_pkg;

    // Default password length in digits.
    localparam int PASS_LEN_DEF = 5;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_READY_CODE = 3'd0;
    localparam logic [2:0] REG_OPEN_LIMIT = 3'd1;
    localparam logic [2:0] REG_HOLD_LIMIT = 3'd2;
    localparam logic [2:0] REG_CLOSE_LIMIT = 3'd3;
    localparam logic [2:0] REG_ALARM_LIMIT = 3'd4;
    localparam logic [2:0] REG_ATTEMPTS = 3'd5;

    // Register reset values.
    localparam logic [7:0] READY_CODE_RST = 8'd16;
    localparam logic [7:0] OPEN_LIMIT_RST = 8'd15;
    localparam logic [7:0] HOLD_LIMIT_RST = 8'd18;
    localparam logic [7:0] CLOSE_LIMIT_RST = 8'd33;
    localparam logic [7:0] ALARM_LIMIT_RST = 8'd60;
    localparam logic [3:0] ATTEMPTS_RST = 4'd3;

    // Option keys.
    localparam logic [7:0] KEY_PLUS = 8'h2B;
    localparam logic [7:0] KEY_MINUS = 8'h2D;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Lock phases.
    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_NEW1    = 4'd1,
        PH_NEW2    = 4'd2,
        PH_MAIN    = 4'd3,
        PH_ENTER   = 4'd4,
        PH_OPENING = 4'd5,
        PH_OPENED  = 4'd6,
        PH_CLOSING = 4'd7,
        PH_WARNING = 4'd8
    } phase_t;

    // Status codes reported in each result.
    typedef enum logic [3:0] {
        ST_MISMATCH = 4'd0,
        ST_MATCH    = 4'd1,
        ST_MAIN     = 4'd2,
        ST_ENTER    = 4'd3,
        ST_OPENING  = 4'd4,
        ST_OPENED   = 4'd5,
        ST_CLOSING  = 4'd6,
        ST_NEWPW    = 4'd7,
        ST_WARNING  = 4'd8
    } status_t;

    // Motor drive codes.
    typedef enum logic [1:0] {
        MOTOR_STOP  = 2'd0,
        MOTOR_CW    = 2'd1,
        MOTOR_CCW   = 2'd2
    } motor_t;

    // Option chosen in the main menu.
    typedef enum logic [1:0] {
        OPT_OTHER = 2'd0,
        OPT_PLUS  = 2'd1,
        OPT_MINUS = 2'd2
    } option_t;

    // Configuration values handed from the register block to the core.
    typedef struct packed {
        logic [7:0] ready_code;
        logic [7:0] open_limit;
        logic [7:0] hold_limit;
        logic [7:0] close_limit;
        logic [7:0] alarm_limit;
        logic [3:0] attempts_allowed;
    } cfg_t;

    // One result record.
    typedef struct packed {
        logic [3:0] status_code;
        logic [1:0] motor_drive;
        logic       buzzer_en;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/pwlock_in_if.sv =====
// ----------------------------------------------------------------------------
// Password lock input channel
// Valid/ready channel carrying one received byte or one-second tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwlock_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_value;

    modport source (output valid, output cmd, output byte_value, input ready);
    modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

`default_nettype wire

// ===== design/pwlock_out_if.sv =====
// ----------------------------------------------------------------------------
// Password lock result channel
// Valid/ready channel carrying one status result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwlock_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status_code;
    logic [1:0] motor_drive;
    logic       buzzer_en;
    logic       last;

    modport source (output valid, output status_code, output motor_drive,
                    output buzzer_en, output last, input ready);
    modport sink (input valid, input status_code, input motor_drive,
                  input buzzer_en, input last, output ready);
endinterface

`default_nettype wire

// ===== design/password_lock_controller.sv =====
// ----------------------------------------------------------------------------
// Password lock controller
// Combination lock sequencer: password setup, option menu, timed door
// motion and wrong-entry alarm.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per item: cmd 0 with a received byte, or cmd 1
//   for a one-second tick. out_ch carries status results (status code, motor
//   drive, buzzer, last flag); an item causes zero, one or two results, and
//   the final one of an item has last set.
//   The item is processed at the edge it is accepted; its results appear on
//   out_ch the next cycle unless older results wait in the queue. Items are
//   accepted one per cycle while in_ch.ready is high; an item that
//   completes a matching password entry produces two results, sent in turn.
//   A four-entry result queue parts the two channels: in_ch.ready drops when
//   fewer than two queue slots remain, so a stalled receiver holds the input
//   off once the queue fills and no result is lost.
//   Reset puts the lock in the waiting-for-ready-byte phase, clears counters
//   and the queue, and loads register defaults. The user writes registers
//   over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module password_lock_controller #(
    parameter int PASS_LEN = pwlock_pkg::PASS_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pwlock_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pwlock_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pwlock_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                   pready,
    pwlock_in_if.sink                              in_ch,
    pwlock_out_if.source                           out_ch
);
    import pwlock_pkg::*;

    cfg_t cfg;

    // Configuration registers.
    pwlock_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Lock state machine and result queue.
    pwlock_core #(
        .PASS_LEN (PASS_LEN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// ===== design/pwlock_cfg.sv =====
// ----------------------------------------------------------------------------
// Password lock configuration registers
// APB-style register block holding the session code, timer limits and the
// allowed number of wrong entries.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlock_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pwlock_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pwlock_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pwlock_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                   pready,
    output pwlock_pkg::cfg_t                       cfg
);
    import pwlock_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_code       <= READY_CODE_RST;
            cfg_reg.open_limit       <= OPEN_LIMIT_RST;
            cfg_reg.hold_limit       <= HOLD_LIMIT_RST;
            cfg_reg.close_limit      <= CLOSE_LIMIT_RST;
            cfg_reg.alarm_limit      <= ALARM_LIMIT_RST;
            cfg_reg.attempts_allowed <= ATTEMPTS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_READY_CODE:  cfg_reg.ready_code       <= pwdata[7:0];
                REG_OPEN_LIMIT:  cfg_reg.open_limit       <= pwdata[7:0];
                REG_HOLD_LIMIT:  cfg_reg.hold_limit       <= pwdata[7:0];
                REG_CLOSE_LIMIT: cfg_reg.close_limit      <= pwdata[7:0];
                REG_ALARM_LIMIT: cfg_reg.alarm_limit      <= pwdata[7:0];
                REG_ATTEMPTS:    cfg_reg.attempts_allowed <= pwdata[3:0];
                default:         ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_READY_CODE:  prdata[7:0] = cfg_reg.ready_code;
            REG_OPEN_LIMIT:  prdata[7:0] = cfg_reg.open_limit;
            REG_HOLD_LIMIT:  prdata[7:0] = cfg_reg.hold_limit;
            REG_CLOSE_LIMIT: prdata[7:0] = cfg_reg.close_limit;
            REG_ALARM_LIMIT: prdata[7:0] = cfg_reg.alarm_limit;
            REG_ATTEMPTS:    prdata[3:0] = cfg_reg.attempts_allowed;
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/pwlock_core.sv =====
// ----------------------------------------------------------------------------
// Password lock core
// Lock state machine with password stores, timers and a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlock_core #(
    parameter int PASS_LEN = pwlock_pkg::PASS_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  pwlock_pkg::cfg_t cfg,
    pwlock_in_if.sink        in_ch,
    pwlock_out_if.source     out_ch
);
    import pwlock_pkg::*;

    localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASS_LEN - 1);

    // State registers.
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] digit_reg, digit_next;
    logic             differs_reg, differs_next;
    logic [3:0]       wrong_reg, wrong_next;
    logic [7:0]       sec_reg, sec_next;
    option_t          option_reg, option_next;
    logic [7:0]       cand_reg [PASS_LEN];
    logic [7:0]       pass_reg [PASS_LEN];
    logic             cand_we;
    logic             pass_copy;

    // Result queue.
    result_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QCNT_W-1:0] count_reg;
    result_t           res0, res1;
    logic [1:0]        push_n;
    logic              pop;

    // Shared decode of the accepted item.
    logic       in_fire;
    logic       is_tick;
    logic [7:0] b;
    logic       last_digit;
    logic [IDX_W-1:0] digit_adv;
    logic       new2_diff;
    logic       enter_diff;
    logic       attempts_out;
    logic       timer_done;
    logic [7:0] sec_inc;
    option_t    key_option;

    assign in_ch.ready  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign is_tick      = (in_ch.cmd == CMD_TICK);
    assign b            = in_ch.byte_value;
    assign last_digit   = (digit_reg == LAST_IDX);
    assign digit_adv    = last_digit ? '0 : digit_reg + 1'b1;
    assign new2_diff    = differs_reg || (cand_reg[digit_reg] != b);
    assign enter_diff   = differs_reg || (pass_reg[digit_reg] != b);
    assign attempts_out = ({1'b0, wrong_reg} + 5'd1) >= {1'b0, cfg.attempts_allowed};
    assign sec_inc      = (sec_reg == 8'hFF) ? sec_reg : sec_reg + 8'd1;
    assign key_option   = (b == KEY_PLUS) ? OPT_PLUS :
                          (b == KEY_MINUS) ? OPT_MINUS : OPT_OTHER;

    // Limit for the current timed phase.
    always_comb
    begin
        case (phase_reg)
            PH_OPENING: timer_done = (sec_reg >= cfg.open_limit);
            PH_OPENED:  timer_done = (sec_reg >= cfg.hold_limit);
            PH_CLOSING: timer_done = (sec_reg >= cfg.close_limit);
            PH_WARNING: timer_done = (sec_reg >= cfg.alarm_limit);
            default:    timer_done = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next   = phase_reg;
        digit_next   = digit_reg;
        differs_next = differs_reg;
        wrong_next   = wrong_reg;
        sec_next     = sec_reg;
        option_next  = option_reg;
        cand_we      = 1'b0;
        pass_copy    = 1'b0;
        if (in_fire && is_tick)
        begin
            unique case (phase_reg)
                PH_OPENING:
                begin
                    sec_next = sec_inc;
                    if (timer_done)
                        phase_next = PH_OPENED;
                end
                PH_OPENED:
                begin
                    sec_next = sec_inc;
                    if (timer_done)
                        phase_next = PH_CLOSING;
                end
                PH_CLOSING:
                begin
                    sec_next = sec_inc;
                    if (timer_done)
                    begin
                        phase_next = PH_MAIN;
                        sec_next   = '0;
                    end
                end
                PH_WARNING:
                begin
                    sec_next = sec_inc;
                    if (timer_done)
                    begin
                        phase_next = PH_MAIN;
                        sec_next   = '0;
                        wrong_next = '0;
                    end
                end
                default: ;
            endcase
        end
        else if (in_fire)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (b == cfg.ready_code)
                    begin
                        phase_next = PH_NEW1;
                        digit_next = '0;
                    end
                end
                PH_NEW1:
                begin
                    cand_we    = 1'b1;
                    digit_next = digit_adv;
                    if (last_digit)
                    begin
                        phase_next   = PH_NEW2;
                        differs_next = 1'b0;
                    end
                end
                PH_NEW2:
                begin
                    digit_next   = digit_adv;
                    differs_next = new2_diff;
                    if (last_digit)
                    begin
                        differs_next = 1'b0;
                        if (new2_diff)
                            phase_next = PH_NEW1;
                        else
                        begin
                            pass_copy  = 1'b1;
                            phase_next = PH_MAIN;
                        end
                    end
                end
                PH_MAIN:
                begin
                    option_next  = key_option;
                    phase_next   = PH_ENTER;
                    digit_next   = '0;
                    differs_next = 1'b0;
                end
                PH_ENTER:
                begin
                    digit_next   = digit_adv;
                    differs_next = enter_diff;
                    if (last_digit)
                    begin
                        differs_next = 1'b0;
                        if (!enter_diff)
                        begin
                            wrong_next = '0;
                            case (option_reg)
                                OPT_PLUS:
                                begin
                                    phase_next = PH_OPENING;
                                    sec_next   = '0;
                                end
                                OPT_MINUS: phase_next = PH_NEW1;
                                default:   phase_next = PH_MAIN;
                            endcase
                        end
                        else if (attempts_out)
                        begin
                            phase_next = PH_WARNING;
                            sec_next   = '0;
                        end
                        else
                            wrong_next = wrong_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Results caused by the accepted item.
    always_comb
    begin
        res0   = '{status_code: ST_MAIN, motor_drive: MOTOR_STOP, buzzer_en: 1'b0,
                   last: 1'b1};
        res1   = res0;
        push_n = 2'd0;
        if (in_fire && is_tick)
        begin
            if (timer_done)
            begin
                push_n = 2'd1;
                unique case (phase_reg)
                    PH_OPENING: res0.status_code = ST_OPENED;
                    PH_OPENED:
                    begin
                        res0.status_code = ST_CLOSING;
                        res0.motor_drive = MOTOR_CCW;
                    end
                    default:    res0.status_code = ST_MAIN;
                endcase
            end
        end
        else if (in_fire)
        begin
            unique case (phase_reg)
                PH_NEW2:
                begin
                    if (last_digit)
                    begin
                        if (new2_diff)
                        begin
                            push_n           = 2'd1;
                            res0.status_code = ST_MISMATCH;
                        end
                        else
                        begin
                            push_n           = 2'd2;
                            res0.status_code = ST_MATCH;
                            res0.last        = 1'b0;
                            res1.status_code = ST_MAIN;
                        end
                    end
                end
                PH_MAIN:
                begin
                    push_n           = 2'd1;
                    res0.status_code = ST_ENTER;
                end
                PH_ENTER:
                begin
                    if (last_digit)
                    begin
                        push_n = 2'd1;
                        if (!enter_diff)
                        begin
                            push_n           = 2'd2;
                            res0.status_code = ST_MATCH;
                            res0.last        = 1'b0;
                            case (option_reg)
                                OPT_PLUS:
                                begin
                                    res1.status_code = ST_OPENING;
                                    res1.motor_drive = MOTOR_CW;
                                end
                                OPT_MINUS: res1.status_code = ST_NEWPW;
                                default:   res1.status_code = ST_MAIN;
                            endcase
                        end
                        else if (attempts_out)
                        begin
                            res0.status_code = ST_WARNING;
                            res0.buzzer_en   = 1'b1;
                        end
                        else
                            res0.status_code = ST_MISMATCH;
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            digit_reg   <= '0;
            differs_reg <= 1'b0;
            wrong_reg   <= '0;
            sec_reg     <= '0;
            option_reg  <= OPT_OTHER;
        end
        else
        begin
            phase_reg   <= phase_next;
            digit_reg   <= digit_next;
            differs_reg <= differs_next;
            wrong_reg   <= wrong_next;
            sec_reg     <= sec_next;
            option_reg  <= option_next;
        end
    end

    // Password stores; contents are only read after being written.
    always_ff @(posedge clk)
    begin
        if (cand_we)
            cand_reg[digit_reg] <= b;
        if (pass_copy)
            pass_reg <= cand_reg;
    end

    // Result queue pointers.
    assign pop = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + QPTR_W'(pop);
            tail_reg  <= tail_reg + QPTR_W'(push_n);
            count_reg <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[tail_reg] <= res0;
        if (push_n == 2'd2)
            q_reg[tail_reg + 1'b1] <= res1;
    end

    assign out_ch.valid       = (count_reg != '0);
    assign out_ch.status_code = q_reg[head_reg].status_code;
    assign out_ch.motor_drive = q_reg[head_reg].motor_drive;
    assign out_ch.buzzer_en   = q_reg[head_reg].buzzer_en;
    assign out_ch.last        = q_reg[head_reg].last;

    // The queue always has room for both results of an accepted item.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("result queue accepted an item without room");

    // Timed phases only advance on a tick.
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_OPENING && phase_next == PH_OPENED) |-> (in_fire && is_tick))
        else $error("opening finished without a tick");

    // Two results only come from a completed password entry.
    a_pair_source: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (!is_tick && last_digit &&
                              (phase_reg == PH_NEW2 || phase_reg == PH_ENTER)))
        else $error("result pair from an unexpected phase");

    // The final pushed result of an item carries the last flag.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        ((push_n == 2'd1) |-> res0.last) and ((push_n == 2'd2) |-> (res1.last && !res0.last)))
        else $error("last flag misplaced");

    // The buzzer sounds only in the warning result.
    a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.buzzer_en) |-> (out_ch.status_code == ST_WARNING))
        else $error("buzzer on outside the warning result");

endmodule

`default_nettype wire

// ===== sim/pwlock_checker.sv =====
// ----------------------------------------------------------------------------
// Password lock result checker
// Watches the request and result channels and the register port. It keeps
// its own copy of the lock state and registers, predicts the results of each
// accepted request, and compares every accepted result with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwlock_checker
    import pwlock_pkg::*;
#(
    parameter int PASS_LEN = PASS_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pwlock_in_if                  in_mon,
    pwlock_out_if                 out_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    pending
);

    // Shadow copy of the lock state and the registers.
    phase_t     lock_phase;
    logic [2:0] digit_pos;
    logic [7:0] entry_buf [PASS_LEN];
    logic [7:0] saved_code [PASS_LEN];
    logic       entry_bad;
    logic [3:0] miss_count;
    logic [7:0] sec_count;
    option_t    menu_opt;
    cfg_t       regs;

    // Results still owed by the block, oldest first.
    result_t    owed_results [$];
    result_t    got;
    result_t    want;

    function automatic void add_result(status_t s, motor_t m, logic buz);
        owed_results.push_back(result_t'({s, m, buz, 1'b0}));
    endfunction

    // Moves to the next digit; returns 1 when the last digit was just taken.
    function automatic logic advance_digit(input logic [2:0] idx);
        if (int'(idx) + 1 >= PASS_LEN)
        begin
            digit_pos = 3'd0;
            return 1'b1;
        end
        digit_pos = idx + 3'd1;
        return 1'b0;
    endfunction

    task automatic note_failure(input string what, input result_t exp_r, input result_t act_r);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t pwlock check: %s: expected status=%0d motor=%0d buzzer=%0d last=%0d,",
                     $time, what, exp_r.status_code, exp_r.motor_drive, exp_r.buzzer_en,
                     exp_r.last);
        if (fail_count <= 10)
            $display("    got status=%0d motor=%0d buzzer=%0d last=%0d",
                     act_r.status_code, act_r.motor_drive, act_r.buzzer_en, act_r.last);
    endtask

    // Works out the results of one accepted request and queues them.
    task automatic predict_request(input logic is_tick, input logic [7:0] b);
        int         base;
        logic [2:0] idx;
        logic       timed;
        logic       expired;
        logic [7:0] limit;
        result_t    tail;
        base = owed_results.size();
        idx = (int'(digit_pos) >= PASS_LEN) ? 3'd0 : digit_pos;
        if (is_tick)
        begin
            // Each timed phase has its own limit; other phases ignore ticks.
            timed = 1'b1;
            case (lock_phase)
                PH_OPENING: limit = regs.open_limit;
                PH_OPENED:  limit = regs.hold_limit;
                PH_CLOSING: limit = regs.close_limit;
                PH_WARNING: limit = regs.alarm_limit;
                default:
                begin
                    limit = 8'd0;
                    timed = 1'b0;
                end
            endcase
            expired = timed && (sec_count >= limit);
            if (timed && sec_count != 8'hFF)
                sec_count = sec_count + 8'd1;
            if (expired)
            begin
                case (lock_phase)
                    PH_OPENING:
                    begin
                        lock_phase = PH_OPENED;
                        add_result(ST_OPENED, MOTOR_STOP, 1'b0);
                    end
                    PH_OPENED:
                    begin
                        lock_phase = PH_CLOSING;
                        add_result(ST_CLOSING, MOTOR_CCW, 1'b0);
                    end
                    PH_CLOSING:
                    begin
                        lock_phase = PH_MAIN;
                        sec_count = 8'd0;
                        add_result(ST_MAIN, MOTOR_STOP, 1'b0);
                    end
                    default:
                    begin
                        lock_phase = PH_MAIN;
                        sec_count = 8'd0;
                        miss_count = 4'd0;
                        add_result(ST_MAIN, MOTOR_STOP, 1'b0);
                    end
                endcase
            end
        end
        else
        begin
            case (lock_phase)
                PH_WAIT:
                begin
                    if (b == regs.ready_code)
                    begin
                        lock_phase = PH_NEW1;
                        digit_pos = 3'd0;
                    end
                end
                PH_NEW1:
                begin
                    entry_buf[idx] = b;
                    if (advance_digit(idx))
                    begin
                        lock_phase = PH_NEW2;
                        entry_bad = 1'b0;
                    end
                end
                PH_NEW2:
                begin
                    if (entry_buf[idx] != b)
                        entry_bad = 1'b1;
                    if (advance_digit(idx))
                    begin
                        if (entry_bad)
                        begin
                            lock_phase = PH_NEW1;
                            add_result(ST_MISMATCH, MOTOR_STOP, 1'b0);
                        end
                        else
                        begin
                            saved_code = entry_buf;
                            lock_phase = PH_MAIN;
                            add_result(ST_MATCH, MOTOR_STOP, 1'b0);
                            add_result(ST_MAIN, MOTOR_STOP, 1'b0);
                        end
                        entry_bad = 1'b0;
                    end
                end
                PH_MAIN:
                begin
                    if (b == KEY_PLUS)
                        menu_opt = OPT_PLUS;
                    else if (b == KEY_MINUS)
                        menu_opt = OPT_MINUS;
                    else
                        menu_opt = OPT_OTHER;
                    lock_phase = PH_ENTER;
                    digit_pos = 3'd0;
                    entry_bad = 1'b0;
                    add_result(ST_ENTER, MOTOR_STOP, 1'b0);
                end
                PH_ENTER:
                begin
                    if (saved_code[idx] != b)
                        entry_bad = 1'b1;
                    if (advance_digit(idx))
                    begin
                        if (!entry_bad)
                        begin
                            // A good entry clears the wrong-entry count.
                            miss_count = 4'd0;
                            add_result(ST_MATCH, MOTOR_STOP, 1'b0);
                            if (menu_opt == OPT_PLUS)
                            begin
                                lock_phase = PH_OPENING;
                                sec_count = 8'd0;
                                add_result(ST_OPENING, MOTOR_CW, 1'b0);
                            end
                            else if (menu_opt == OPT_MINUS)
                            begin
                                lock_phase = PH_NEW1;
                                add_result(ST_NEWPW, MOTOR_STOP, 1'b0);
                            end
                            else
                            begin
                                lock_phase = PH_MAIN;
                                add_result(ST_MAIN, MOTOR_STOP, 1'b0);
                            end
                        end
                        else if ({1'b0, miss_count} + 5'd1 >= {1'b0, regs.attempts_allowed})
                        begin
                            lock_phase = PH_WARNING;
                            sec_count = 8'd0;
                            add_result(ST_WARNING, MOTOR_STOP, 1'b1);
                        end
                        else
                        begin
                            miss_count = miss_count + 4'd1;
                            add_result(ST_MISMATCH, MOTOR_STOP, 1'b0);
                        end
                        entry_bad = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // Flag the final result of this request.
        if (owed_results.size() > base)
        begin
            tail = owed_results.pop_back();
            tail.last = 1'b1;
            owed_results.push_back(tail);
        end
    endtask

    // Results are checked first, then register writes and new requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_phase = PH_WAIT;
            digit_pos = 3'd0;
            entry_bad = 1'b0;
            miss_count = 4'd0;
            sec_count = 8'd0;
            menu_opt = OPT_OTHER;
            regs.ready_code = READY_CODE_RST;
            regs.open_limit = OPEN_LIMIT_RST;
            regs.hold_limit = HOLD_LIMIT_RST;
            regs.close_limit = CLOSE_LIMIT_RST;
            regs.alarm_limit = ALARM_LIMIT_RST;
            regs.attempts_allowed = ATTEMPTS_RST;
            for (int i = 0; i < PASS_LEN; i++)
            begin
                entry_buf[i] = 8'd0;
                saved_code[i] = 8'd0;
            end
            owed_results.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
            begin
                got.status_code = out_mon.status_code;
                got.motor_drive = out_mon.motor_drive;
                got.buzzer_en = out_mon.buzzer_en;
                got.last = out_mon.last;
                if (owed_results.size() == 0)
                    note_failure("result with nothing expected", '0, got);
                else
                begin
                    want = owed_results.pop_front();
                    if (got !== want)
                        note_failure("result mismatch", want, got);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_READY_CODE:  regs.ready_code = pwdata[7:0];
                    REG_OPEN_LIMIT:  regs.open_limit = pwdata[7:0];
                    REG_HOLD_LIMIT:  regs.hold_limit = pwdata[7:0];
                    REG_CLOSE_LIMIT: regs.close_limit = pwdata[7:0];
                    REG_ALARM_LIMIT: regs.alarm_limit = pwdata[7:0];
                    REG_ATTEMPTS:    regs.attempts_allowed = pwdata[3:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
                predict_request(in_mon.cmd, in_mon.byte_value);

            pending <= owed_results.size();
        end
    end

endmodule

// ===== sim/tb_password_lock_controller.sv =====
// ----------------------------------------------------------------------------
// Password lock controller testbench
// Drives bytes and ticks through whole lock sessions: password setup, menu
// keys with good and bad entries, timed door runs and alarms, under several
// register settings and idle patterns. A checker module predicts and compares
// every result; this top makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_password_lock_controller;
    import pwlock_pkg::*;

    localparam int PW_LEN = PASS_LEN_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ROUNDS = 8;
    localparam int ROUND_ITEMS = 165;

    typedef logic [PW_LEN-1:0][7:0] pw_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int      fail_count;
    int      pending;
    int      cycle_count = 0;
    int      item_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      round_end;
    int      pick;
    logic [3:0] attempts_cfg;
    status_t last_status = ST_MISMATCH;
    pw_t     cur_pw;
    pw_t     first_pw;
    pw_t     bad_pw;
    logic [7:0] key;

    pwlock_in_if  in_if ();
    pwlock_out_if out_if ();

    password_lock_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    pwlock_checker #(
        .PASS_LEN (PW_LEN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_if),
        .out_mon    (out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_password_lock_controller NOT OK");
            $finish;
        end
    end

    // Result receiver with random stalls.
    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Status of the final result of the latest request that had any.
    always @(posedge clk)
    begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1 && out_if.last === 1'b1)
            last_status <= status_t'(out_if.status_code);
    end

    // Presents one request after a random gap and holds it until accepted.
    task automatic send_req(input logic c, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= c;
        in_if.byte_value <= b;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        item_count++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // An occasional tick in a phase that ignores it.
    task automatic maybe_stray_tick();
        if ($urandom_range(99) < 5)
            send_req(CMD_TICK, 8'($urandom));
    endtask

    task automatic enter_digits(input pw_t pw);
        for (int i = 0; i < PW_LEN; i++)
        begin
            maybe_stray_tick();
            send_req(CMD_BYTE, pw[i]);
        end
    endtask

    function automatic pw_t corrupt(input pw_t p);
        int i;
        i = $urandom_range(PW_LEN - 1);
        p[i] = p[i] ^ 8'($urandom_range(1, 255));
        return p;
    endfunction

    // One register write: setup cycle, then access cycle. psel is left high
    // so that back-to-back writes need no extra assignment in one step.
    task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
    endtask

    task automatic write_config(input logic [7:0] code, input logic [7:0] open_l,
                                input logic [7:0] hold_l, input logic [7:0] close_l,
                                input logic [7:0] alarm_l, input logic [3:0] tries);
        wait_drained();
        repeat (4) @(posedge clk);
        apb_write(REG_READY_CODE, code);
        apb_write(REG_OPEN_LIMIT, open_l);
        apb_write(REG_HOLD_LIMIT, hold_l);
        apb_write(REG_CLOSE_LIMIT, close_l);
        apb_write(REG_ALARM_LIMIT, alarm_l);
        apb_write(REG_ATTEMPTS, {4'd0, tries});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        attempts_cfg = tries;
        @(posedge clk);
    endtask

    // Ticks through a door run or an alarm until the lock is back at the
    // main options. Between bursts the lock is known to be in a timed phase,
    // so a stray byte there must be ignored.
    task automatic run_timed();
        while (last_status != ST_MAIN)
        begin
            if ($urandom_range(99) < 20)
                send_req(CMD_BYTE, 8'($urandom));
            repeat ($urandom_range(1, 16))
                send_req(CMD_TICK, 8'($urandom));
            wait_drained();
        end
    endtask

    // Sets a new password; the second entry sometimes differs.
    task automatic new_password();
        pw_t  fresh;
        pw_t  again;
        logic done;
        done = 1'b0;
        while (!done)
        begin
            for (int i = 0; i < PW_LEN; i++)
            begin
                pick = $urandom_range(99);
                fresh[i] = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF : 8'($urandom);
            end
            again = ($urandom_range(99) < 20) ? corrupt(fresh) : fresh;
            enter_digits(fresh);
            enter_digits(again);
            wait_drained();
            if (last_status == ST_MAIN)
            begin
                cur_pw = fresh;
                done = 1'b1;
            end
        end
    endtask

    // Menu key plus one password entry, then whatever that entry started.
    task automatic menu_action(input logic [7:0] k, input pw_t pw);
        maybe_stray_tick();
        send_req(CMD_BYTE, k);
        enter_digits(pw);
        wait_drained();
        case (last_status)
            ST_OPENING, ST_WARNING: run_timed();
            ST_NEWPW:               new_password();
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        in_if.valid <= 1'b0;
        in_if.cmd <= CMD_BYTE;
        in_if.byte_value <= 8'd0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        attempts_cfg = ATTEMPTS_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Session start: an ignored tick and wrong ready bytes first.
        send_req(CMD_TICK, 8'hA5);
        send_req(CMD_BYTE, 8'h00);
        send_req(CMD_BYTE, 8'hFF);
        send_req(CMD_BYTE, READY_CODE_RST);

        // Setup with differing entries, then with agreeing ones.
        first_pw = {8'h80, KEY_MINUS, KEY_PLUS, 8'hFF, 8'h00};
        bad_pw = first_pw;
        bad_pw[PW_LEN-1] = 8'h81;
        enter_digits(first_pw);
        enter_digits(bad_pw);
        wait_drained();
        enter_digits(first_pw);
        enter_digits(first_pw);
        wait_drained();
        cur_pw = first_pw;

        // Unknown menu key with a good entry.
        menu_action(8'h00, cur_pw);

        // Random sessions under changing registers and idle patterns.
        for (int r = 0; r < ROUNDS; r++)
        begin
            case (r)
                0:
                begin
                end
                1: write_config(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 4'd1);
                2: write_config(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15);
                default:
                    write_config(8'($urandom), 8'($urandom_range(40)), 8'($urandom_range(40)),
                                 8'($urandom_range(40)), 8'($urandom_range(40)),
                                 4'($urandom_range(1, 15)));
            endcase
            case (r % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            round_end = item_count + ROUND_ITEMS;
            while (item_count < round_end)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    // Enough wrong entries in a row to raise the alarm.
                    repeat (attempts_cfg)
                        menu_action(8'($urandom), corrupt(cur_pw));
                end
                else
                begin
                    pick = $urandom_range(99);
                    key = (pick < 45) ? KEY_PLUS : (pick < 65) ? KEY_MINUS : 8'($urandom);
                    menu_action(key, ($urandom_range(99) < 15) ? corrupt(cur_pw) : cur_pw);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_password_lock_controller OK");
        else
            $display("tb_password_lock_controller NOT OK");
        $finish;
    end

endmodule
